>>> rtl/core/linear_probe_hash_table_core_assert.svh
// Assertion macros for the linear probe hash table core.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

`define LPHT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lpht_pkg.sv
// Shared constants, codes and types for the linear probe hash table core.
// No dependencies.
package lpht_pkg;

    localparam int MAX_BUCKETS_DEF = 1024;
    localparam int KEY_BITS_DEF    = 31;

    localparam int CFG_W    = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 10;
    localparam int FIFO_DEPTH = 2;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ERASED   = 3'd5;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
    } res_t;

endpackage

>>> rtl/core/lpht_mod.sv
// Bit-serial restoring remainder unit: dividend modulo divisor, one bit per cycle.
// Depends on lpht_pkg.
module lpht_mod import lpht_pkg::*; #(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [KEY_BITS-1:0]                  dividend,
    input  logic [$clog2(MAX_BUCKETS+1)-1:0]     divisor,
    output logic                                 done,
    output logic [$clog2(MAX_BUCKETS)-1:0]       rem
);
    localparam int IDX_W = $clog2(MAX_BUCKETS);
    localparam int DIV_W = $clog2(MAX_BUCKETS + 1);
    localparam int CNT_W = $clog2(KEY_BITS + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [KEY_BITS-1:0] q_reg;
    logic [DIV_W-1:0]    r_reg;
    logic [DIV_W:0]      trial;
    logic [DIV_W-1:0]    r_next;

    always_comb begin
        trial = {r_reg, q_reg[KEY_BITS-1]};
        if (trial >= {1'b0, divisor}) begin
            r_next = DIV_W'(trial - {1'b0, divisor});
        end else begin
            r_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KEY_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
        end else if (busy_reg) begin
            q_reg <= {q_reg[KEY_BITS-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg[IDX_W-1:0];

endmodule

>>> rtl/core/lpht_front.sv
// Front end: takes requests, works out the home bucket and queues them.
// Depends on lpht_pkg and lpht_mod.
module lpht_front import lpht_pkg::*; #(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             init_done,
    input  logic [$clog2(MAX_BUCKETS+1)-1:0]                 div_eff,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic [ACTION_W-1:0]                              in_action,
    input  logic [KEY_BITS-1:0]                              in_key,
    output logic                                             push_valid,
    input  logic                                             push_ready,
    output logic [ACTION_W+KEY_BITS+$clog2(MAX_BUCKETS)-1:0] push_data
);
    localparam int IDX_W = $clog2(MAX_BUCKETS);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MOD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]          st_reg;
    logic [ACTION_W-1:0] act_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [IDX_W-1:0]    home_reg;
    logic                accept;
    logic                mod_done;
    logic [IDX_W-1:0]    mod_rem;

    assign in_ready   = init_done && (st_reg == F_IDLE);
    assign accept     = in_valid && in_ready;
    assign push_valid = (st_reg == F_PUSH);
    assign push_data  = {home_reg, key_reg, act_reg};

    lpht_mod #(.MAX_BUCKETS(MAX_BUCKETS), .KEY_BITS(KEY_BITS)) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend (in_key),
        .divisor  (div_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= F_IDLE;
        end else begin
            case (st_reg)
                F_IDLE: begin
                    if (accept) begin
                        st_reg <= F_MOD;
                    end
                end
                F_MOD: begin
                    if (mod_done) begin
                        st_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (push_ready) begin
                        st_reg <= F_IDLE;
                    end
                end
                default: st_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= in_action;
            key_reg <= in_key;
        end
        if (st_reg == F_MOD && mod_done) begin
            home_reg <= mod_rem;
        end
    end

endmodule

>>> rtl/core/lpht_fifo.sv
// Short request queue between the front end and the table engine.
// Depends on lpht_pkg.
module lpht_fifo import lpht_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/lpht_back.sv
// Table engine: bucket memory, probe walk, insert, find and backward-shift erase.
// Depends on lpht_pkg and lpht_mod.
module lpht_back import lpht_pkg::*; #(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic [$clog2(MAX_BUCKETS+1)-1:0]                 div_eff,
    output logic                                             init_done,
    input  logic                                             pop_valid,
    output logic                                             pop_ready,
    input  logic [ACTION_W+KEY_BITS+$clog2(MAX_BUCKETS)-1:0] pop_data,
    output logic                                             res_valid,
    input  logic                                             res_ready,
    output res_t                                             res
);
    localparam int IDX_W = $clog2(MAX_BUCKETS);
    localparam int DIV_W = $clog2(MAX_BUCKETS + 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_PRD  = 4'd2;
    localparam logic [3:0] S_PCHK = 4'd3;
    localparam logic [3:0] S_EWR  = 4'd4;
    localparam logic [3:0] S_ERD  = 4'd5;
    localparam logic [3:0] S_ECHK = 4'd6;
    localparam logic [3:0] S_EMOD = 4'd7;
    localparam logic [3:0] S_EMV1 = 4'd8;
    localparam logic [3:0] S_EMV2 = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [KEY_BITS:0] mem [MAX_BUCKETS];
    logic [KEY_BITS:0] rd_reg;
    logic              we;
    logic [IDX_W-1:0]  wa;
    logic [KEY_BITS:0] wd;
    logic [IDX_W-1:0]  ra;

    logic [3:0]          st_reg, st_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] mkey_reg, mkey_next;
    logic [IDX_W-1:0]    b_reg, b_next;
    logic [DIV_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [IDX_W-1:0]    gap_reg, gap_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [DIV_W-1:0]    moved_reg, moved_next;
    res_t                fin_reg, fin_next;
    logic                ov_reg, ov_next;
    res_t                out_reg, out_next;

    logic                rd_occ;
    logic [KEY_BITS-1:0] rd_key;
    logic [IDX_W-1:0]    b_inc, cur_inc, pos_inc;
    logic                mod_start, mod_done;
    logic [IDX_W-1:0]    mod_rem;
    logic                home_in;

    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] b,
                                                  input logic [DIV_W-1:0] d);
        logic [DIV_W-1:0] bx;
        bx = DIV_W'(b) + 1'b1;
        return (bx >= d) ? '0 : bx[IDX_W-1:0];
    endfunction

    assign rd_occ  = rd_reg[KEY_BITS];
    assign rd_key  = rd_reg[KEY_BITS-1:0];
    assign b_inc   = step_idx(b_reg, div_eff);
    assign cur_inc = step_idx(cur_reg, div_eff);
    assign pos_inc = step_idx(pos_reg, div_eff);

    always_comb begin
        if (gap_reg < cur_reg) begin
            home_in = (mod_rem > gap_reg) && (mod_rem <= cur_reg);
        end else begin
            home_in = (mod_rem > gap_reg) || (mod_rem <= cur_reg);
        end
    end

    lpht_mod #(.MAX_BUCKETS(MAX_BUCKETS), .KEY_BITS(KEY_BITS)) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (rd_key),
        .divisor  (div_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[ra];
    end

    assign init_done = (st_reg != S_CLR);
    assign pop_ready = (st_reg == S_IDLE);
    assign res_valid = ov_reg;
    assign res       = out_reg;

    always_comb begin
        st_next    = st_reg;
        clr_next   = clr_reg;
        act_next   = act_reg;
        key_next   = key_reg;
        mkey_next  = mkey_reg;
        b_next     = b_reg;
        n_next     = n_reg;
        pos_next   = pos_reg;
        gap_next   = gap_reg;
        cur_next   = cur_reg;
        moved_next = moved_reg;
        fin_next   = fin_reg;
        ov_next    = ov_reg && !res_ready;
        out_next   = out_reg;
        we         = 1'b0;
        wa         = b_reg;
        wd         = {1'b1, key_reg};
        ra         = b_reg;
        mod_start  = 1'b0;

        case (st_reg)
            S_CLR: begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(MAX_BUCKETS - 1)) begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop_valid) begin
                    act_next = pop_data[ACTION_W-1:0];
                    key_next = pop_data[ACTION_W+KEY_BITS-1:ACTION_W];
                    b_next   = pop_data[ACTION_W+KEY_BITS+IDX_W-1:ACTION_W+KEY_BITS];
                    n_next   = '0;
                    if (pop_data[ACTION_W-1:0] == ACT_INSERT
                            || pop_data[ACTION_W-1:0] == ACT_FIND
                            || pop_data[ACTION_W-1:0] == ACT_ERASE) begin
                        st_next = S_PRD;
                    end else begin
                        fin_next = '{status: ST_ABSENT, value: '0};
                        st_next  = S_DONE;
                    end
                end
            end
            S_PRD: begin
                ra      = b_reg;
                st_next = S_PCHK;
            end
            S_PCHK: begin
                if (!rd_occ) begin
                    if (act_reg == ACT_INSERT) begin
                        we       = 1'b1;
                        wa       = b_reg;
                        wd       = {1'b1, key_reg};
                        fin_next = '{status: ST_INSERTED, value: VALUE_W'(b_reg)};
                    end else begin
                        fin_next = '{status: ST_ABSENT, value: '0};
                    end
                    st_next = S_DONE;
                end else if (rd_key == key_reg) begin
                    case (act_reg)
                        ACT_INSERT: begin
                            fin_next = '{status: ST_PRESENT, value: '0};
                            st_next  = S_DONE;
                        end
                        ACT_FIND: begin
                            fin_next = '{status: ST_FOUND, value: VALUE_W'(b_reg)};
                            st_next  = S_DONE;
                        end
                        default: begin
                            pos_next = b_reg;
                            st_next  = S_EWR;
                        end
                    endcase
                end else if (n_reg + 1'b1 >= div_eff) begin
                    if (act_reg == ACT_INSERT) begin
                        fin_next = '{status: ST_FULL, value: '0};
                    end else begin
                        fin_next = '{status: ST_ABSENT, value: '0};
                    end
                    st_next = S_DONE;
                end else begin
                    b_next  = b_inc;
                    n_next  = n_reg + 1'b1;
                    st_next = S_PRD;
                end
            end
            S_EWR: begin
                we         = 1'b1;
                wa         = pos_reg;
                wd         = '0;
                gap_next   = pos_reg;
                cur_next   = pos_inc;
                moved_next = '0;
                st_next    = S_ERD;
            end
            S_ERD: begin
                ra = cur_reg;
                if (cur_reg == pos_reg) begin
                    fin_next = '{status: ST_ERASED, value: VALUE_W'(moved_reg)};
                    st_next  = S_DONE;
                end else begin
                    st_next = S_ECHK;
                end
            end
            S_ECHK: begin
                if (!rd_occ) begin
                    fin_next = '{status: ST_ERASED, value: VALUE_W'(moved_reg)};
                    st_next  = S_DONE;
                end else begin
                    mkey_next = rd_key;
                    mod_start = 1'b1;
                    st_next   = S_EMOD;
                end
            end
            S_EMOD: begin
                if (mod_done) begin
                    if (home_in) begin
                        cur_next = cur_inc;
                        st_next  = S_ERD;
                    end else begin
                        st_next = S_EMV1;
                    end
                end
            end
            S_EMV1: begin
                we      = 1'b1;
                wa      = gap_reg;
                wd      = {1'b1, mkey_reg};
                st_next = S_EMV2;
            end
            S_EMV2: begin
                we         = 1'b1;
                wa         = cur_reg;
                wd         = '0;
                gap_next   = cur_reg;
                moved_next = moved_reg + 1'b1;
                cur_next   = cur_inc;
                st_next    = S_ERD;
            end
            S_DONE: begin
                if (!ov_reg || res_ready) begin
                    ov_next  = 1'b1;
                    out_next = fin_reg;
                    st_next  = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= S_CLR;
            clr_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        key_reg   <= key_next;
        mkey_reg  <= mkey_next;
        b_reg     <= b_next;
        n_reg     <= n_next;
        pos_reg   <= pos_next;
        gap_reg   <= gap_next;
        cur_reg   <= cur_next;
        moved_reg <= moved_next;
        fin_reg   <= fin_next;
        out_reg   <= out_next;
    end

endmodule

>>> rtl/core/linear_probe_hash_table_core.sv
// Linear probing hash table with backward-shift erase; one result per request.
// Front end: bit-serial home bucket, one request at a time; it takes no new request until
// the last one is pushed into the queue. Erase walks the cluster after the erased bucket,
// works out the home bucket of each entry examined and shifts entries back into the gap.
// After reset the bucket memory is cleared before any request is taken.
`include "linear_probe_hash_table_core_assert.svh"

module linear_probe_hash_table_core import lpht_pkg::*; #(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    localparam int S_TDATA_W  = ((ACTION_W + KEY_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((STATUS_W + VALUE_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: action, key, zero fill.
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: status, value, zero fill.
    output logic [M_TDATA_W-1:0] m_tdata
);
    localparam int IDX_W  = $clog2(MAX_BUCKETS);
    localparam int DIV_W  = $clog2(MAX_BUCKETS + 1);
    localparam int ITEM_W = ACTION_W + KEY_BITS + IDX_W;
    localparam int DCMP_W = (CFG_W > DIV_W) ? CFG_W : DIV_W;

    logic [CFG_W-1:0]  div_reg;
    logic [DIV_W-1:0]  div_eff;
    logic              init_done;
    logic              push_valid, fifo_full, fifo_ne, pop_ready;
    logic [ITEM_W-1:0] push_data, pop_data;
    res_t              res;
    logic              value_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            div_reg <= cfg_data;
        end
    end

    always_comb begin
        if (div_reg == '0) begin
            div_eff = DIV_W'(1);
        end else if (DCMP_W'(div_reg) > DCMP_W'(MAX_BUCKETS)) begin
            div_eff = DIV_W'(MAX_BUCKETS);
        end else begin
            div_eff = DIV_W'(div_reg);
        end
    end

    lpht_front #(.MAX_BUCKETS(MAX_BUCKETS), .KEY_BITS(KEY_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .init_done  (init_done),
        .div_eff    (div_eff),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tdata[ACTION_W-1:0]),
        .in_key     (s_tdata[ACTION_W+KEY_BITS-1:ACTION_W]),
        .push_valid (push_valid),
        .push_ready (!fifo_full),
        .push_data  (push_data)
    );

    lpht_fifo #(.WIDTH(ITEM_W)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid && !fifo_full),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (fifo_ne && pop_ready),
        .not_empty (fifo_ne),
        .pop_data  (pop_data)
    );

    lpht_back #(.MAX_BUCKETS(MAX_BUCKETS), .KEY_BITS(KEY_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .div_eff   (div_eff),
        .init_done (init_done),
        .pop_valid (fifo_ne),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = M_TDATA_W'({res.value, res.status});

    assign value_free = m_tvalid && res.status != ST_INSERTED && res.status != ST_FOUND
                        && res.status != ST_ERASED;

    `LPHT_ASSERT_IMPL(a_no_accept_in_clear, !init_done, !s_tready, "request taken during clear")
    `LPHT_ASSERT_NEXT(a_clear_stays_done, init_done, init_done, "clear pass restarted")
    `LPHT_ASSERT_IMPL(a_value_zero, value_free, res.value == '0, "value not zero for status")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for linear_probe_hash_table_core: a directed table and random
// insert/find/erase traffic with some unused actions, checked against a behavioural hash table in this file.
// Depends on lpht_pkg and the core RTL.
module testbench;
    import lpht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = 1024;
    localparam int KB = 31;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [39:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;

    linear_probe_hash_table_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    logic [KB-1:0] tbl_key [NB];
    bit tbl_used [NB];
    logic [CFG_W-1:0] divisor_reg = CFG_RESET;
    res_t expected_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_erased = 0;
    int n_full = 0;
    bit hold_off = 1'b0;
    bit stall_req = 1'b0;

    function automatic int eff_divisor();
        int d;
        d = divisor_reg;
        if (d == 0) d = 1;
        if (d > NB) d = NB;
        return d;
    endfunction

    function automatic int locate(logic [KB-1:0] k, int d);
        int b;
        b = k % d;
        for (int n = 0; n < d; n++) begin
            if (!tbl_used[b]) return -1;
            if (tbl_key[b] == k) return b;
            b = (b + 1 >= d) ? 0 : b + 1;
        end
        return -1;
    endfunction

    function automatic bit cyc_between(int lo, int hi, int h);
        if (lo < hi) return h > lo && h <= hi;
        return h > lo || h <= hi;
    endfunction

    function automatic res_t hash_apply(logic [ACTION_W-1:0] act, logic [KB-1:0] k);
        res_t r;
        int d, p, b, stop, gap, cur, moved;
        d = eff_divisor();
        r.status = ST_ABSENT;
        r.value = '0;
        p = locate(k, d);
        if (act == ACT_INSERT) begin
            if (p >= 0) begin
                r.status = ST_PRESENT;
            end else begin
                r.status = ST_FULL;
                b = k % d;
                for (int n = 0; n < d; n++) begin
                    if (!tbl_used[b]) begin
                        tbl_key[b] = k;
                        tbl_used[b] = 1'b1;
                        r.status = ST_INSERTED;
                        r.value = b[VALUE_W-1:0];
                        break;
                    end
                    b = (b + 1 >= d) ? 0 : b + 1;
                end
            end
        end else if (act == ACT_FIND) begin
            if (p >= 0) begin
                r.status = ST_FOUND;
                r.value = p[VALUE_W-1:0];
            end
        end else if (act == ACT_ERASE && p >= 0) begin
            moved = 0;
            gap = p;
            tbl_used[p] = 1'b0;
            stop = (p + 1 >= d) ? 0 : p + 1;
            while (tbl_used[stop] && stop != p) stop = (stop + 1 >= d) ? 0 : stop + 1;
            cur = (p + 1 >= d) ? 0 : p + 1;
            while (cur != stop) begin
                if (!cyc_between(gap, cur, tbl_key[cur] % d)) begin
                    tbl_key[gap] = tbl_key[cur];
                    tbl_used[gap] = 1'b1;
                    tbl_used[cur] = 1'b0;
                    moved++;
                    gap = cur;
                end
                cur = (cur + 1 >= d) ? 0 : cur + 1;
            end
            r.status = ST_ERASED;
            r.value = moved[VALUE_W-1:0];
        end
        return r;
    endfunction

    // Checks each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_recv++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status %0d value %0d", $time,
                    m_tdata[2:0], m_tdata[12:3]);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[2:0] !== want.status || m_tdata[12:3] !== want.value
                        || m_tdata[15:13] !== 3'b0) begin
                    $display("%0t: expected status %0d value %0d, got status %0d value %0d",
                        $time, want.status, want.value, m_tdata[2:0], m_tdata[12:3]);
                    errors++;
                end
                if (want.status == ST_ERASED) n_erased++;
                if (want.status == ST_FULL) n_full++;
            end
        end
    end

    // Receiver: own stall pattern, plus a long hold-off on request.
    initial begin
        int pat;
        pat = 0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                for (int i = 0; i < 300; i++) @(negedge aclk);
                hold_off = 1'b0;
            end
            pat++;
            if (stall_req) m_tready <= ((pat % 7) < 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            else m_tready <= 1'b1;
        end
    end

    task automatic send_item(logic [ACTION_W-1:0] act, logic [KB-1:0] k, bit chk,
                             logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] val);
        res_t r;
        s_tdata <= {7'b0, k, act};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = hash_apply(act, k);
        if (chk && (r.status != st || r.value != val)) begin
            $display("%0t: table row expected status %0d value %0d, model gives %0d %0d",
                $time, st, val, r.status, r.value);
            errors++;
        end
        expected_q.push_back(r);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_all();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (2200) @(negedge aclk);
    endtask

    task automatic set_divisor(logic [CFG_W-1:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        divisor_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [KB-1:0] k;
        bit chk;
        logic [STATUS_W-1:0] st;
        logic [VALUE_W-1:0] val;
    } row_t;

    row_t rows[] = '{
        '{ACT_FIND, 31'd5, 1, ST_ABSENT, 10'd0},
        '{ACT_ERASE, 31'd5, 1, ST_ABSENT, 10'd0},
        '{ACT_INSERT, 31'd0, 1, ST_INSERTED, 10'd0},
        '{ACT_INSERT, 31'h7FFFFFFF, 1, ST_INSERTED, 10'd1023},
        '{ACT_INSERT, 31'd1024, 1, ST_INSERTED, 10'd1},
        '{ACT_INSERT, 31'd1024, 1, ST_PRESENT, 10'd0},
        '{ACT_FIND, 31'h7FFFFFFF, 1, ST_FOUND, 10'd1023},
        '{ACT_INSERT, 31'd2047, 1, ST_INSERTED, 10'd2},
        '{ACT_ERASE, 31'd0, 0, '0, '0},
        '{ACT_FIND, 31'd2047, 0, '0, '0},
        '{ACT_UNUSED, 31'd1024, 1, ST_ABSENT, 10'd0},
        '{ACT_INSERT, 31'h55555555, 0, '0, '0},
        '{ACT_INSERT, 31'h2AAAAAAA, 0, '0, '0},
        '{ACT_ERASE, 31'h7FFFFFFF, 0, '0, '0},
        '{ACT_FIND, 31'd1024, 0, '0, '0}
    };

    task automatic random_phase(int count, int keyspan);
        int burst;
        int gap;
        logic [ACTION_W-1:0] a;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            burst--;
            case ($urandom_range(0, 19))
                0: a = ACT_UNUSED;
                1, 2, 3, 4, 5, 6, 7, 8: a = ACT_INSERT;
                9, 10, 11, 12, 13: a = ACT_FIND;
                default: a = ACT_ERASE;
            endcase
            if ($urandom_range(0, 15) == 0) send_item(a, 31'($urandom()), 0, '0, '0);
            else send_item(a, 31'($urandom_range(0, keyspan)), 0, '0, '0);
            if (i == count / 2 && count > 100) begin
                hold_off = 1'b1;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NB; i++) tbl_used[i] = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        stall_req = 1'b0;
        foreach (rows[i]) send_item(rows[i].act, rows[i].k, rows[i].chk, rows[i].st, rows[i].val);
        drain_all();
        stall_req = 1'b1;
        random_phase(300, 4000);
        drain_all();
        set_divisor(11'd1);
        random_phase(40, 20);
        drain_all();
        set_divisor(11'd0);
        random_phase(40, 20);
        drain_all();
        set_divisor(11'd2047);
        random_phase(150, 3000);
        drain_all();
        set_divisor(11'd7);
        random_phase(300, 60);
        drain_all();
        set_divisor(11'd13);
        random_phase(300, 200);
        drain_all();
        set_divisor(11'd1024);
        random_phase(250, 2000000);
        drain_all();
        $display("Sent %0d requests, %0d results (%0d erases, %0d full) over divisors 0..2047.",
            n_sent, n_recv, n_erased, n_full);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/lpht_pkg.sv
rtl/core/lpht_mod.sv
rtl/core/lpht_front.sv
rtl/core/lpht_fifo.sv
rtl/core/lpht_back.sv
rtl/core/linear_probe_hash_table_core.sv
tb/testbench.sv
